// File: design/multi_waveform_generator_top_macros.svh
// Assertion macros used by the waveform generator top module.
`ifndef MULTI_WAVEFORM_GENERATOR_TOP_MACROS_SVH
`define MULTI_WAVEFORM_GENERATOR_TOP_MACROS_SVH

`define MWG_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define MWG_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// File: design/mwg_pkg.sv
package mwg_pkg;

  localparam int unsigned OutWidthDef = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicW = 33;
  localparam logic signed [CordicW-1:0] CordicX0 = 33'sd652032874;
  localparam logic [15:0] SampleCountRst = 16'd1024;

  localparam logic [CfgIdxW-1:0] RegWaveKind = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAmplitude = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPeriod = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSampleCount = 2'd3;

  typedef enum logic [2:0] {
    WAVE_DC = 3'd0,
    WAVE_SINE = 3'd1,
    WAVE_COSINE = 3'd2,
    WAVE_SQUARE = 3'd3,
    WAVE_SAW = 3'd4,
    WAVE_TRIANGLE = 3'd5
  } wave_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_TURN,
    ST_CORDIC,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [49:0] num;
    logic [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [49:0] quo;
    logic [33:0] rem;
  } div_rsp_t;

  function automatic logic [23:0] atan_turn(input logic [3:0] i);
    logic [23:0] v;
    begin
      unique case (i)
        4'd0: v = 24'd2097152;
        4'd1: v = 24'd1238021;
        4'd2: v = 24'd654136;
        4'd3: v = 24'd332050;
        4'd4: v = 24'd166669;
        4'd5: v = 24'd83416;
        4'd6: v = 24'd41718;
        4'd7: v = 24'd20860;
        4'd8: v = 24'd10430;
        4'd9: v = 24'd5215;
        4'd10: v = 24'd2608;
        4'd11: v = 24'd1304;
        4'd12: v = 24'd652;
        4'd13: v = 24'd326;
        4'd14: v = 24'd163;
        default: v = 24'd81;
      endcase
      return v;
    end
  endfunction

endpackage

// File: design/mwg_stream_if.sv
interface mwg_stream_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/mwg_divider.sv
module mwg_divider
  import mwg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [49:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [33:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [34:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, quo_r[49]} - {1'b0, den_r};
    if (req.start) begin
      quo_nxt = req.num;
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = 6'd50;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[34]) begin
        rem_nxt = {rem_r[32:0], quo_r[49]};
        quo_nxt = {quo_r[48:0], 1'b0};
      end else begin
        rem_nxt = trial[33:0];
        quo_nxt = {quo_r[48:0], 1'b1};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo = quo_r;
  assign rsp.rem = rem_r;

endmodule

// File: design/mwg_cordic.sv
module mwg_cordic
  import mwg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [23:0]               turn,
  output logic                      done,
  output logic signed [CordicW-1:0] sin_out,
  output logic signed [CordicW-1:0] cos_out
);

  logic signed [CordicW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [25:0] z_r, z_nxt;
  logic [3:0] i_r, i_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic signed [25:0] s;
  logic signed [CordicW-1:0] dx, dy;

  // Shift with truncation toward zero.
  function automatic logic signed [CordicW-1:0] tdiv(input logic signed [CordicW-1:0] v,
                                                      input logic [3:0] n);
    logic signed [CordicW-1:0] a;
    begin
      a = v < 0 ? -v : v;
      a = a >>> n;
      return v < 0 ? -a : a;
    end
  endfunction

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; done_nxt = 1'b0; neg_nxt = neg_r;
    s = turn[23] ? $signed({2'b11, turn}) : $signed({2'b00, turn});
    dx = tdiv(x_r, i_r);
    dy = tdiv(y_r, i_r);
    if (start) begin
      neg_nxt = 1'b0;
      if (s > 26'sd4194304) begin
        s = 26'sd8388608 - s;
        neg_nxt = 1'b1;
      end else if (s < -26'sd4194304) begin
        s = -26'sd8388608 - s;
        neg_nxt = 1'b1;
      end
      x_nxt = CordicX0; y_nxt = '0; z_nxt = s; i_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - dy; y_nxt = y_r + dx;
        z_nxt = z_r - $signed({2'b00, atan_turn(i_r)});
      end else begin
        x_nxt = x_r + dy; y_nxt = y_r - dx;
        z_nxt = z_r + $signed({2'b00, atan_turn(i_r)});
      end
      i_nxt = i_r + 4'd1;
      if (i_r == 4'(CordicSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt; neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign sin_out = y_r;
  assign cos_out = neg_r ? -x_r : x_r;

endmodule

// File: design/multi_waveform_generator_top.sv
// Channel | Direction | Payload
// in      | sink      | restart
// out     | source    | sample, last_sample, error
// cfg     | write     | wave_kind, amplitude, period, sample_count
// One item at a time. Dc and square skip the shared restoring divider (one
// quotient bit a cycle) and the CORDIC (one step a cycle); triangle and sawtooth
// (period above one) use the divider once; sine and cosine use it, the CORDIC,
// then it again. A position not below the period is first reduced by the
// divider. Reset is synchronous; the next item waits until the result is taken.
`include "multi_waveform_generator_top_macros.svh"
module multi_waveform_generator_top
  import mwg_pkg::*;
#(
  parameter int unsigned OUT_WIDTH = OutWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  mwg_stream_if.sink          in_ch,
  mwg_stream_if.source        out_ch
);

  localparam logic signed [OUT_WIDTH:0] Lim = (OUT_WIDTH+1)'((1 << (OUT_WIDTH - 1)) - 1);

  logic [2:0]  wave_kind_r;
  logic [14:0] amplitude_r;
  logic [15:0] period_r, sample_count_r;
  logic [15:0] pos_r, pos_nxt, idx_r, idx_nxt;
  state_t state_r, state_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic        neg_r, neg_nxt, err_r, err_nxt;
  logic [49:0] acc_r, acc_nxt;
  logic signed [OUT_WIDTH-1:0] sample_r, sample_nxt;
  logic        last_r, last_nxt;
  logic        ovalid_r, ovalid_nxt;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        cstart, cdone;
  logic signed [CordicW-1:0] csin, ccos, cres;
  logic [33:0] den_r, den_nxt;
  logic [15:0] rpos;
  logic signed [19:0] tri_d;
  logic [49:0] prod;
  logic signed [51:0] sv;

  mwg_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  mwg_cordic u_cordic (.clk(clk), .rst_n(rst_n), .start(cstart), .turn(drsp.quo[23:0]),
                       .done(cdone), .sin_out(csin), .cos_out(ccos));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_kind_r <= '0;
      amplitude_r <= '0;
      period_r <= '0;
      sample_count_r <= SampleCountRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegWaveKind: wave_kind_r <= cfg_data[2:0];
        RegAmplitude: amplitude_r <= cfg_data[14:0];
        RegPeriod: period_r <= cfg_data;
        RegSampleCount: sample_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid && !ovalid_r) begin
        if (period_r == '0) state_nxt = ST_DONE;
        else if ((in_ch.data[0] ? 16'd0 : pos_r) >= period_r) state_nxt = ST_MOD;
        else state_nxt = ST_MUL;
      end
      ST_MOD: if (drsp.done) state_nxt = ST_MUL;
      ST_MUL: begin
        if (kind_r == WAVE_SINE || kind_r == WAVE_COSINE) state_nxt = ST_TURN;
        else if ((kind_r == WAVE_SAW && period_r != 16'd1) || kind_r == WAVE_TRIANGLE)
          state_nxt = ST_DIV;
        else state_nxt = ST_DONE;
      end
      ST_TURN: if (drsp.done) state_nxt = ST_CORDIC;
      ST_CORDIC: if (cdone) state_nxt = ST_DIV;
      ST_DIV: if (drsp.done) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r; idx_nxt = idx_r; kind_nxt = kind_r; neg_nxt = neg_r;
    err_nxt = err_r; acc_nxt = acc_r; den_nxt = den_r;
    sample_nxt = sample_r; last_nxt = last_r; ovalid_nxt = ovalid_r;
    dreq = '0; cstart = 1'b0;
    rpos = pos_r;
    tri_d = '0; prod = '0; sv = '0;
    cres = (kind_r == WAVE_COSINE) ? ccos : csin;
    if (out_ch.ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid && !ovalid_r) begin
        if (in_ch.data[0]) begin
          pos_nxt = '0;
          idx_nxt = '0;
        end
        kind_nxt = wave_kind_r;
        err_nxt = 1'b0;
        neg_nxt = 1'b0;
        acc_nxt = 50'(amplitude_r);
        if (period_r == '0) begin
          kind_nxt = WAVE_DC;
          pos_nxt = '0;
        end
        dreq.start = 1'b1;
        dreq.num = 50'(in_ch.data[0] ? 16'd0 : pos_r);
        dreq.den = 34'(period_r);
      end
      ST_MOD: if (drsp.done) pos_nxt = drsp.rem[15:0];
      ST_MUL: begin
        unique case (kind_r)
          WAVE_DC: acc_nxt = 50'(amplitude_r);
          WAVE_SQUARE: begin
            acc_nxt = 50'(amplitude_r);
            neg_nxt = !(pos_r < (period_r >> 1));
          end
          WAVE_SAW: begin
            if (period_r == 16'd1) begin
              err_nxt = 1'b1;
              acc_nxt = '0;
            end else begin
              prod = 50'(amplitude_r) * 50'(pos_r);
              acc_nxt = prod;
              den_nxt = 34'(period_r - 16'd1);
            end
          end
          WAVE_TRIANGLE: begin
            tri_d = $signed({2'b00, pos_r, 2'b00}) - $signed({3'b000, period_r, 1'b0});
            if (tri_d < 0) tri_d = -tri_d;
            tri_d = tri_d - $signed({4'b0000, period_r});
            neg_nxt = tri_d < 0;
            prod = 50'(amplitude_r) * 50'(17'(neg_nxt ? -tri_d : tri_d));
            acc_nxt = prod;
            den_nxt = 34'(period_r);
          end
          WAVE_SINE, WAVE_COSINE: begin
            dreq.start = 1'b1;
            dreq.num = {10'd0, pos_r, 24'd0};
            dreq.den = 34'(period_r);
          end
          default: acc_nxt = '0;
        endcase
        if (kind_r == WAVE_SAW || kind_r == WAVE_TRIANGLE) begin
          dreq.start = (kind_r == WAVE_TRIANGLE) || (period_r != 16'd1);
          dreq.num = (kind_r == WAVE_TRIANGLE || period_r != 16'd1) ?
                     {prod[48:0], 1'b0} : 50'd0;
          dreq.num = dreq.num + {16'd0, den_nxt};
          dreq.den = {den_nxt[32:0], 1'b0};
        end
      end
      ST_TURN: if (drsp.done) cstart = 1'b1;
      ST_CORDIC: if (cdone) begin
        neg_nxt = cres < 0;
        prod = 50'(amplitude_r) * 50'(33'(cres < 0 ? -cres : cres));
        dreq.start = 1'b1;
        dreq.num = prod + 50'(35'd1 << 29);
        dreq.den = 34'(35'd1 << 30);
      end
      ST_DIV: if (drsp.done) acc_nxt = drsp.quo;
      ST_DONE: begin
        sv = neg_r ? -$signed({2'b00, acc_r}) : $signed({2'b00, acc_r});
        if (sv > 52'(Lim)) sv = 52'(Lim);
        if (sv < -52'(Lim)) sv = -52'(Lim);
        sample_nxt = sv[OUT_WIDTH-1:0];
        last_nxt = (17'(idx_r) + 17'd1) >= 17'(sample_count_r);
        ovalid_nxt = 1'b1;
        if (last_nxt) begin
          idx_nxt = '0;
          pos_nxt = '0;
        end else begin
          idx_nxt = idx_r + 16'd1;
          if (period_r != '0) pos_nxt = (pos_r + 16'd1 >= period_r) ? 16'd0 : pos_r + 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r <= '0;
      idx_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      idx_r <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
    kind_r <= kind_nxt; neg_r <= neg_nxt; err_r <= err_nxt; acc_r <= acc_nxt;
    den_r <= den_nxt; sample_r <= sample_nxt; last_r <= last_nxt;
  end

  assign in_ch.ready = (state_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = {sample_r, last_r, err_r};

  `MWG_ASSERT_NEXT(a_done_valid, state_r == ST_DONE, ovalid_r)
  `MWG_ASSERT_IMPL(a_busy_nready, state_r != ST_IDLE, !in_ch.ready)
  `MWG_ASSERT_IMPL(a_err_zero, ovalid_r && err_r, sample_r == '0)

endmodule
